[hw/rtl/zsch_pkg.sv]
// Shared definitions for the zero suppression and calibration block.
// Holds item codes, field widths and the default geometry; no dependencies.
`timescale 1ns / 1ps

package zsch_pkg;

   localparam int DEF_DETECTORS = 4;
   localparam int DEF_STRIPS    = 16;
   localparam int DEF_CRYSTALS  = 9;

   localparam int OP_W     = 2;
   localparam int LAYER_W  = 2;
   localparam int DET_W    = 2;
   localparam int CHAN_W   = 4;
   localparam int ADC_W    = 14;
   localparam int SLOPE_W  = 24;
   localparam int OFFSET_W = 32;
   localparam int ENERGY_W = 40;
   localparam int COUNT_W  = 5;
   localparam int PROD_W   = SLOPE_W + ADC_W;
   localparam int ENTRY_W  = OFFSET_W + SLOPE_W + ADC_W;

   localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
   localparam logic [OP_W-1:0] OP_END    = 2'd2;

   localparam logic [LAYER_W-1:0] LAYER_CRYSTAL = 2'd3;
   localparam int LAYERS = 4;

   localparam logic KIND_HIT     = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   function automatic logic [COUNT_W-1:0] max3(input logic [COUNT_W-1:0] a,
                                               input logic [COUNT_W-1:0] b,
                                               input logic [COUNT_W-1:0] c);
      logic [COUNT_W-1:0] m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      return m;
   endfunction

endpackage

[hw/rtl/zero_suppress_calibrate_hits.sv]
// Top level of the zero suppression and calibration block.
// Depends on zsch_pkg and zsch_ram.
`timescale 1ns / 1ps

// The block takes one beat per cycle while req_stall is low. It presents a hit or an event
// summary on the result port. The calibration memory is read at the accepting edge, the s2
// registers hold the threshold compare and the slope multiply, and the intercept is added
// into the output register. Threshold, slope and intercept share one memory, silicon entries
// first and crystal entries after them, and a load is written in the cycle it is taken, so a
// sample may follow its load directly. Tables hold no defined value until loaded and need
// no clearing after reset. Loads, unused op codes and out-of-range addresses give no result
// beat.

module zero_suppress_calibrate_hits
   import zsch_pkg::*;
#(
   parameter int DETECTORS = DEF_DETECTORS,
   parameter int STRIPS    = DEF_STRIPS,
   parameter int CRYSTALS  = DEF_CRYSTALS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [OP_W-1:0]            req_op,
   input  logic [LAYER_W-1:0]         req_layer,
   input  logic [DET_W-1:0]           req_detector,
   input  logic [CHAN_W-1:0]          req_channel,
   input  logic [ADC_W-1:0]           req_adc,
   input  logic [ADC_W-1:0]           req_threshold,
   input  logic [SLOPE_W-1:0]         req_slope,
   input  logic signed [OFFSET_W-1:0] req_offset,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_kind,
   output logic [LAYER_W-1:0]         rsp_hit_layer,
   output logic [CHAN_W-1:0]          rsp_hit_channel,
   output logic [ADC_W-1:0]           rsp_raw_value,
   output logic signed [ENERGY_W-1:0] rsp_energy,
   output logic [COUNT_W-1:0]         rsp_count_first,
   output logic [COUNT_W-1:0]         rsp_count_front,
   output logic [COUNT_W-1:0]         rsp_count_back,
   output logic [COUNT_W-1:0]         rsp_count_crystal,
   output logic [COUNT_W-1:0]         rsp_count_largest
);

   localparam int SI_DEPTH  = 3 * DETECTORS * STRIPS;
   localparam int CSI_DEPTH = DETECTORS * CRYSTALS;
   localparam int DEPTH     = SI_DEPTH + CSI_DEPTH;
   localparam int AW        = $clog2(DEPTH);

   logic             accept;
   logic             is_si;
   logic             in_range;
   logic [AW-1:0]    addr;
   logic             wr_en;
   logic             rd_en;
   logic [ENTRY_W-1:0] wr_data;
   logic [ENTRY_W-1:0] rd_data;
   logic             ready1;
   logic             ready2;
   logic             ready3;

   logic               s1_valid_ff;
   logic               s1_end_ff;
   logic               s1_si_ff;
   logic [LAYER_W-1:0] s1_layer_ff;
   logic [CHAN_W-1:0]  s1_channel_ff;
   logic [ADC_W-1:0]   s1_adc_ff;

   logic                 s1_hit;
   logic                 s1_move;
   logic [COUNT_W-1:0]   counts_ff [LAYERS];
   logic [COUNT_W-1:0]   counts_in [LAYERS];

   logic                 s2_valid_ff;
   logic                 s2_kind_ff;
   logic [LAYER_W-1:0]   s2_layer_ff;
   logic [CHAN_W-1:0]    s2_channel_ff;
   logic [ADC_W-1:0]     s2_adc_ff;
   logic [PROD_W-1:0]    s2_prod_ff;
   logic [OFFSET_W-1:0]  s2_offset_ff;
   logic [COUNT_W-1:0]   s2_counts_ff [LAYERS];
   logic [COUNT_W-1:0]   s2_largest_ff;

   logic                 rsp_valid_ff;
   logic                 rsp_kind_ff;
   logic [LAYER_W-1:0]   rsp_layer_ff;
   logic [CHAN_W-1:0]    rsp_channel_ff;
   logic [ADC_W-1:0]     rsp_adc_ff;
   logic [ENERGY_W-1:0]  rsp_energy_ff;
   logic [COUNT_W-1:0]   rsp_counts_ff [LAYERS];
   logic [COUNT_W-1:0]   rsp_largest_ff;
   logic [ENERGY_W-1:0]  energy_in;

   assign ready3    = !rsp_valid_ff || !rsp_stall;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req_stall = !ready1;
   assign accept    = req_valid && ready1;

   always_comb begin
      is_si = (req_layer != LAYER_CRYSTAL);
      if (is_si) begin
         in_range = (int'(req_detector) < DETECTORS) && (int'(req_channel) < STRIPS);
         addr = AW'((int'(req_layer) * DETECTORS + int'(req_detector)) * STRIPS
                    + int'(req_channel));
      end else begin
         in_range = (int'(req_detector) < DETECTORS) && (int'(req_channel) < CRYSTALS);
         addr = AW'(SI_DEPTH + int'(req_detector) * CRYSTALS + int'(req_channel));
      end
   end

   assign wr_en   = accept && (req_op == OP_LOAD) && in_range;
   assign rd_en   = accept && (req_op == OP_SAMPLE) && in_range;
   assign wr_data = is_si ? {req_offset, req_slope, req_threshold}
                          : {{(OFFSET_W + SLOPE_W){1'b0}}, req_threshold};

   zsch_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ready1) begin
         s1_valid_ff <= accept && (rd_en || (req_op == OP_END));
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_end_ff     <= (req_op == OP_END);
         s1_si_ff      <= is_si;
         s1_layer_ff   <= req_layer;
         s1_channel_ff <= req_channel;
         s1_adc_ff     <= req_adc;
      end
   end

   assign s1_move = s1_valid_ff && ready2;
   assign s1_hit  = !s1_end_ff && (s1_adc_ff > rd_data[ADC_W-1:0]);

   always_comb begin
      for (int i = 0; i < LAYERS; i++) begin
         counts_in[i] = counts_ff[i];
         if (s1_move && s1_end_ff) begin
            counts_in[i] = '0;
         end else if (s1_move && s1_hit && (s1_layer_ff == LAYER_W'(i))
                      && (counts_ff[i] != COUNT_MAX)) begin
            counts_in[i] = counts_ff[i] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAYERS; i++) begin
            counts_ff[i] <= '0;
         end
         s2_valid_ff <= 1'b0;
      end else begin
         for (int i = 0; i < LAYERS; i++) begin
            counts_ff[i] <= counts_in[i];
         end
         if (ready2) begin
            s2_valid_ff <= s1_valid_ff && (s1_end_ff || s1_hit);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_kind_ff    <= s1_end_ff ? KIND_SUMMARY : KIND_HIT;
         s2_layer_ff   <= s1_end_ff ? '0 : s1_layer_ff;
         s2_channel_ff <= s1_end_ff ? '0 : s1_channel_ff;
         s2_adc_ff     <= s1_end_ff ? '0 : s1_adc_ff;
         if (s1_si_ff && !s1_end_ff) begin
            s2_prod_ff   <= PROD_W'(rd_data[ADC_W +: SLOPE_W]) * PROD_W'(s1_adc_ff);
            s2_offset_ff <= rd_data[ADC_W + SLOPE_W +: OFFSET_W];
         end else begin
            s2_prod_ff   <= '0;
            s2_offset_ff <= '0;
         end
         for (int i = 0; i < LAYERS; i++) begin
            s2_counts_ff[i] <= s1_end_ff ? counts_ff[i] : '0;
         end
         s2_largest_ff <= s1_end_ff ? max3(counts_ff[0], counts_ff[1], counts_ff[2]) : '0;
      end
   end

   assign energy_in = ENERGY_W'(s2_prod_ff)
                    + {{(ENERGY_W - OFFSET_W){s2_offset_ff[OFFSET_W-1]}}, s2_offset_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3 && s2_valid_ff) begin
         rsp_kind_ff    <= s2_kind_ff;
         rsp_layer_ff   <= s2_layer_ff;
         rsp_channel_ff <= s2_channel_ff;
         rsp_adc_ff     <= s2_adc_ff;
         rsp_energy_ff  <= energy_in;
         for (int i = 0; i < LAYERS; i++) begin
            rsp_counts_ff[i] <= s2_counts_ff[i];
         end
         rsp_largest_ff <= s2_largest_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_hit_layer     = rsp_layer_ff;
   assign rsp_hit_channel   = rsp_channel_ff;
   assign rsp_raw_value     = rsp_adc_ff;
   assign rsp_energy        = rsp_energy_ff;
   assign rsp_count_first   = rsp_counts_ff[0];
   assign rsp_count_front   = rsp_counts_ff[1];
   assign rsp_count_back    = rsp_counts_ff[2];
   assign rsp_count_crystal = rsp_counts_ff[3];
   assign rsp_count_largest = rsp_largest_ff;

   a_stall_needs_work: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with an empty read stage");

   a_no_read_and_write: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("table read and write issued for one beat");

   a_end_clears_counts: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_end_ff) |=> (counts_ff[0] == '0) && (counts_ff[1] == '0)
                                  && (counts_ff[2] == '0) && (counts_ff[3] == '0))
      else $error("counters not cleared after end of event");

   a_summary_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_SUMMARY)) |-> (rsp_energy == '0)
                                                 && (rsp_raw_value == '0))
      else $error("summary beat carries hit fields");

endmodule

[hw/rtl/zsch_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module zsch_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[tb/tb_zero_suppress_calibrate_hits.sv]
// Self-checking testbench for zero_suppress_calibrate_hits: a directed table of beats, a
// load of every table entry, then random events, checked beat by beat against fixed records
// or a behavioral predictor. Depends on zsch_pkg and the block's RTL; reads no files.
`timescale 1ns / 1ps

module tb_zero_suppress_calibrate_hits
   import zsch_pkg::*;
();

   localparam int NDET           = DEF_DETECTORS;
   localparam int NSTRIP         = DEF_STRIPS;
   localparam int NCRYS          = DEF_CRYSTALS;
   localparam int SI_ENTRIES     = 3 * NDET * NSTRIP;
   localparam int CSI_ENTRIES    = NDET * NCRYS;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [ADC_W-1:0] ADC_TOP  = '1;
   localparam int ITEMS          = 1650;
   localparam int QUIET_LIMIT    = 4000;
   localparam int SQUEEZE_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 12;

   typedef struct {
      logic [OP_W-1:0]            op;
      logic [LAYER_W-1:0]         layer;
      logic [DET_W-1:0]           det;
      logic [CHAN_W-1:0]          chan;
      logic [ADC_W-1:0]           adc;
      logic [ADC_W-1:0]           thr;
      logic [SLOPE_W-1:0]         slope;
      logic signed [OFFSET_W-1:0] offs;
   } item_type;

   typedef struct {
      logic                       kind;
      logic [LAYER_W-1:0]         layer;
      logic [CHAN_W-1:0]          chan;
      logic [ADC_W-1:0]           raw;
      logic signed [ENERGY_W-1:0] energy;
      logic [COUNT_W-1:0]         first;
      logic [COUNT_W-1:0]         front;
      logic [COUNT_W-1:0]         back;
      logic [COUNT_W-1:0]         crystal;
      logic [COUNT_W-1:0]         largest;
   } record_type;

   typedef struct {
      item_type   it;
      bit         typed;
      bit         emits;
      record_type rec;
   } row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [OP_W-1:0]            req_op = '0;
   logic [LAYER_W-1:0]         req_layer = '0;
   logic [DET_W-1:0]           req_detector = '0;
   logic [CHAN_W-1:0]          req_channel = '0;
   logic [ADC_W-1:0]           req_adc = '0;
   logic [ADC_W-1:0]           req_threshold = '0;
   logic [SLOPE_W-1:0]         req_slope = '0;
   logic signed [OFFSET_W-1:0] req_offset = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b1;
   logic                       rsp_kind;
   logic [LAYER_W-1:0]         rsp_hit_layer;
   logic [CHAN_W-1:0]          rsp_hit_channel;
   logic [ADC_W-1:0]           rsp_raw_value;
   logic signed [ENERGY_W-1:0] rsp_energy;
   logic [COUNT_W-1:0]         rsp_count_first;
   logic [COUNT_W-1:0]         rsp_count_front;
   logic [COUNT_W-1:0]         rsp_count_back;
   logic [COUNT_W-1:0]         rsp_count_crystal;
   logic [COUNT_W-1:0]         rsp_count_largest;

   logic [ADC_W-1:0]           si_thr  [SI_ENTRIES];
   logic [SLOPE_W-1:0]         si_gain [SI_ENTRIES];
   logic signed [OFFSET_W-1:0] si_base [SI_ENTRIES];
   logic [ADC_W-1:0]           csi_thr [CSI_ENTRIES];
   logic [COUNT_W-1:0]         mult    [LAYERS] = '{default: '0};

   record_type records_due[$];
   record_type no_record = '{default: '0};
   row_type    plan[$];
   int      sent = 0;
   int      steady = 0;
   int      mismatches = 0;
   int      hits_seen = 0;
   int      events_seen = 0;
   int      saturated_events = 0;
   int      quiet_cycles = 0;
   bit      squeeze_req = 1'b0;

   zero_suppress_calibrate_hits DUT (.*);

   always #6 clock = ~clock;

   function automatic int entry_index(input item_type it);
      if (it.det >= NDET) return -1;
      if (it.layer == LAYER_CRYSTAL)
         return (it.chan < NCRYS) ? int'(it.det) * NCRYS + int'(it.chan) : -1;
      if (it.chan >= NSTRIP) return -1;
      return (int'(it.layer) * NDET + int'(it.det)) * NSTRIP + int'(it.chan);
   endfunction

   function automatic logic [ADC_W-1:0] threshold_of(input item_type it);
      int idx;
      idx = entry_index(it);
      if (idx < 0) return '0;
      return (it.layer == LAYER_CRYSTAL) ? csi_thr[idx] : si_thr[idx];
   endfunction

   function automatic void calibrate_item(input item_type it, output bit emits,
                                          output record_type rec);
      int idx;
      logic [PROD_W-1:0] prod;
      idx = entry_index(it);
      emits = 1'b0;
      rec = '{default: '0};
      if (it.op == OP_END) begin
         emits = 1'b1;
         rec.kind = KIND_SUMMARY;
         rec.first = mult[0];
         rec.front = mult[1];
         rec.back = mult[2];
         rec.crystal = mult[3];
         rec.largest = mult[0];
         if (mult[1] > rec.largest) rec.largest = mult[1];
         if (mult[2] > rec.largest) rec.largest = mult[2];
         for (int l = 0; l < LAYERS; l++) mult[l] = '0;
      end else if (it.op == OP_LOAD && idx >= 0) begin
         if (it.layer == LAYER_CRYSTAL) begin
            csi_thr[idx] = it.thr;
         end else begin
            si_thr[idx] = it.thr;
            si_gain[idx] = it.slope;
            si_base[idx] = it.offs;
         end
      end else if (it.op == OP_SAMPLE && idx >= 0 && it.adc > threshold_of(it)) begin
         emits = 1'b1;
         if (mult[it.layer] != COUNT_MAX) mult[it.layer] = mult[it.layer] + 1'b1;
         rec.kind = KIND_HIT;
         rec.layer = it.layer;
         rec.chan = it.chan;
         rec.raw = it.adc;
         if (it.layer != LAYER_CRYSTAL) begin
            prod = PROD_W'(si_gain[idx]) * PROD_W'(it.adc);
            rec.energy = $signed({{(ENERGY_W - PROD_W){1'b0}}, prod})
                       + $signed({{(ENERGY_W - OFFSET_W){si_base[idx][OFFSET_W-1]}},
                                  si_base[idx]});
         end
      end
   endfunction

   function automatic item_type beat_of(input logic [OP_W-1:0] op, input int layer,
                                        input int det, input int chan, input int adc,
                                        input int thr, input int slope, input int offs);
      item_type it;
      it.op = op;
      it.layer = LAYER_W'(layer);
      it.det = DET_W'(det);
      it.chan = CHAN_W'(chan);
      it.adc = ADC_W'(adc);
      it.thr = ADC_W'(thr);
      it.slope = SLOPE_W'(slope);
      it.offs = OFFSET_W'(offs);
      return it;
   endfunction

   function automatic item_type random_beat(input logic [OP_W-1:0] op, input int layer,
                                            input int det, input int chan);
      return beat_of(op, layer, det, chan, int'($urandom), int'($urandom), int'($urandom),
                     int'($urandom));
   endfunction

   function automatic logic [ADC_W-1:0] pick_threshold();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return '0;
      if (pick < 15) return ADC_TOP;
      if (pick < 45) return ADC_W'($urandom_range(0, 300));
      return ADC_W'($urandom);
   endfunction

   function automatic logic [ADC_W-1:0] pick_adc(input logic [ADC_W-1:0] t);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) return (t == ADC_TOP) ? ADC_TOP : t + 1'b1;
      if (pick < 40) return t;
      if (pick < 50) return (t == '0) ? '0 : t - 1'b1;
      if (pick < 60) return '0;
      if (pick < 70) return ADC_TOP;
      return ADC_W'($urandom);
   endfunction

   function automatic row_type fixed_row(input item_type it, input bit emits,
                                         input record_type rec);
      row_type r;
      r.it = it;
      r.typed = 1'b1;
      r.emits = emits;
      r.rec = rec;
      return r;
   endfunction

   function automatic row_type checked_row(input item_type it);
      row_type r;
      r = fixed_row(it, 1'b0, no_record);
      r.typed = 1'b0;
      return r;
   endfunction

   function automatic record_type hit_rec(input int layer, input int chan, input int raw,
                                          input longint energy);
      record_type rec;
      rec = '{default: '0};
      rec.kind = KIND_HIT;
      rec.layer = LAYER_W'(layer);
      rec.chan = CHAN_W'(chan);
      rec.raw = ADC_W'(raw);
      rec.energy = ENERGY_W'(energy);
      return rec;
   endfunction

   function automatic record_type empty_summary();
      record_type rec;
      rec = '{default: '0};
      rec.kind = KIND_SUMMARY;
      return rec;
   endfunction

   function automatic void add_row(input row_type r);
      plan = {plan, r};
   endfunction

   function automatic void expect_record(input record_type rec);
      records_due = {records_due, rec};
   endfunction

   task automatic offer(input row_type r);
      bit emits;
      record_type rec;
      int pick;
      int gap;
      req_valid <= 1'b1;
      req_op <= r.it.op;
      req_layer <= r.it.layer;
      req_detector <= r.it.det;
      req_channel <= r.it.chan;
      req_adc <= r.it.adc;
      req_threshold <= r.it.thr;
      req_slope <= r.it.slope;
      req_offset <= r.it.offs;
      do @(posedge clock); while (req_stall !== 1'b0);
      calibrate_item(r.it, emits, rec);
      if (r.typed ? r.emits : emits) expect_record(r.typed ? r.rec : rec);
      sent++;
      if (steady > 0) begin
         steady--;
         gap = 0;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 2) steady = $urandom_range(40, 150);
         gap = (pick < 70) ? 0 : (pick < 95) ? $urandom_range(1, 3) : $urandom_range(6, 30);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic match_field(input string name, input logic signed [63:0] want,
                              input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_results
      record_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (records_due.size() == 0) begin
            $error("result beat of kind %0d arrived with nothing outstanding", rsp_kind);
            mismatches++;
         end else begin
            want = records_due.pop_front();
            if (want.kind == KIND_HIT) begin
               hits_seen++;
            end else begin
               events_seen++;
               if (want.largest == COUNT_MAX || want.crystal == COUNT_MAX) saturated_events++;
            end
            match_field("kind", want.kind, rsp_kind);
            match_field("hit_layer", want.layer, rsp_hit_layer);
            match_field("hit_channel", want.chan, rsp_hit_channel);
            match_field("raw_value", want.raw, rsp_raw_value);
            match_field("energy", want.energy, rsp_energy);
            match_field("count_first", want.first, rsp_count_first);
            match_field("count_front", want.front, rsp_count_front);
            match_field("count_back", want.back, rsp_count_back);
            match_field("count_crystal", want.crystal, rsp_count_crystal);
            match_field("count_largest", want.largest, rsp_count_largest);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : receiver
      int pick;
      int run;
      int hold;
      bit squeezed;
      squeezed = 1'b0;
      forever begin
         if (squeeze_req && !squeezed) begin
            squeezed = 1'b1;
            rsp_stall <= 1'b1;
            repeat (SQUEEZE_CYCLES) @(posedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            run = $urandom_range(40, 150);
            hold = 0;
         end else begin
            run = $urandom_range(0, 8);
            hold = (pick < 95) ? $urandom_range(1, 3) : $urandom_range(8, 40);
         end
         if (run > 0) begin
            rsp_stall <= 1'b0;
            repeat (run) @(posedge clock);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      item_type it;
      int pick;
      int layer;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      add_row(fixed_row(beat_of(OP_END, 0, 0, 0, 0, 0, 0, 0), 1'b1, empty_summary()));
      add_row(fixed_row(beat_of(OP_LOAD, 0, 0, 0, 0, 0, 1, 0), 1'b0, no_record));
      add_row(fixed_row(beat_of(OP_SAMPLE, 0, 0, 0, 0, 0, 0, 0), 1'b0, no_record));
      add_row(fixed_row(beat_of(OP_SAMPLE, 0, 0, 0, 1, 0, 0, 0), 1'b1,
                        hit_rec(0, 0, 1, 1)));
      add_row(fixed_row(beat_of(OP_SAMPLE, 0, 0, 0, 16383, 0, 0, 0), 1'b1,
                        hit_rec(0, 0, 16383, 16383)));
      add_row(fixed_row(beat_of(OP_LOAD, 1, 3, 15, 0, 16383, 24'hFFFFFF, 32'h7FFFFFFF),
                        1'b0, no_record));
      add_row(fixed_row(beat_of(OP_SAMPLE, 1, 3, 15, 16383, 0, 0, 0), 1'b0, no_record));
      add_row(fixed_row(beat_of(OP_LOAD, 2, 2, 7, 0, 100, 24'hFFFFFF, 32'h80000000),
                        1'b0, no_record));
      add_row(checked_row(beat_of(OP_SAMPLE, 2, 2, 7, 16383, 0, 0, 0)));
      add_row(checked_row(beat_of(OP_SAMPLE, 2, 2, 7, 101, 0, 0, 0)));
      add_row(fixed_row(beat_of(OP_SAMPLE, 2, 2, 7, 100, 0, 0, 0), 1'b0, no_record));
      add_row(fixed_row(beat_of(OP_LOAD, 3, 3, 8, 0, 5, 24'hFFFFFF, -1), 1'b0,
                        no_record));
      add_row(fixed_row(beat_of(OP_SAMPLE, 3, 3, 8, 6, 0, 0, 0), 1'b1,
                        hit_rec(3, 8, 6, 0)));
      add_row(fixed_row(beat_of(OP_LOAD, 3, 0, 9, 0, 0, 0, 0), 1'b0, no_record));
      add_row(fixed_row(beat_of(OP_SAMPLE, 3, 0, 9, 16383, 0, 0, 0), 1'b0, no_record));
      add_row(fixed_row(beat_of(OP_SAMPLE, 3, 1, 15, 16383, 0, 0, 0), 1'b0, no_record));
      add_row(fixed_row(random_beat(OP_UNUSED, 1, 1, 5), 1'b0, no_record));
      add_row(fixed_row(beat_of(OP_LOAD, 1, 1, 0, 0, 0, 24'h123456, -5000000), 1'b0,
                        no_record));
      add_row(checked_row(beat_of(OP_SAMPLE, 1, 1, 0, 14'h2AAA, 0, 0, 0)));
      add_row(checked_row(beat_of(OP_SAMPLE, 1, 1, 0, 14'h1555, 0, 0, 0)));
      add_row(checked_row(random_beat(OP_END, 3, 2, 12)));
      add_row(fixed_row(beat_of(OP_END, 0, 0, 0, 0, 0, 0, 0), 1'b1, empty_summary()));
      add_row(fixed_row(beat_of(OP_LOAD, 3, 0, 0, 0, 0, 0, 0), 1'b0, no_record));
      add_row(fixed_row(beat_of(OP_SAMPLE, 3, 0, 0, 16383, 0, 0, 0), 1'b1,
                        hit_rec(3, 0, 16383, 0)));
      add_row(checked_row(beat_of(OP_END, 0, 0, 0, 0, 0, 0, 0)));
      foreach (plan[i]) offer(plan[i]);

      for (int l = 0; l < LAYERS; l++)
         for (int d = 0; d < NDET; d++)
            for (int c = 0; c < 16; c++) begin
               it = random_beat(OP_LOAD, l, d, c);
               it.thr = pick_threshold();
               offer(checked_row(it));
            end

      squeeze_req = 1'b1;
      while (sent < ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 6)) begin
               it = random_beat(OP_LOAD, $urandom_range(0, 3), $urandom_range(0, 3),
                                $urandom_range(0, 15));
               it.thr = pick_threshold();
               offer(checked_row(it));
            end
         end
         if (pick >= 95) begin
            layer = $urandom_range(0, 3);
            for (int d = 0; d < NDET; d++)
               for (int c = 0; c < 16; c++) begin
                  it = random_beat(OP_SAMPLE, layer, d, c);
                  it.adc = ADC_TOP - ADC_W'($urandom_range(0, 3));
                  offer(checked_row(it));
               end
         end else begin
            repeat ($urandom_range(1, 20)) begin
               it = random_beat(OP_SAMPLE, $urandom_range(0, 3), $urandom_range(0, 3),
                                $urandom_range(0, 15));
               if ($urandom_range(0, 19) == 0)
                  it.op = OP_UNUSED;
               else if (it.layer == LAYER_CRYSTAL && $urandom_range(0, 9) != 0)
                  it.chan = CHAN_W'($urandom_range(0, NCRYS - 1));
               if (it.op == OP_SAMPLE && entry_index(it) >= 0)
                  it.adc = pick_adc(threshold_of(it));
               offer(checked_row(it));
            end
         end
         offer(checked_row(random_beat(OP_END, $urandom_range(0, 3), $urandom_range(0, 3),
                                       $urandom_range(0, 15))));
      end
      req_valid <= 1'b0;

      while (records_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Drove %0d request beats; compared %0d hits and %0d event summaries.",
               sent, hits_seen, events_seen);
      $display("%0d events ended with a saturated multiplicity.", saturated_events);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
